FILE: rtl/gbpa_pkg.sv
// Package with sizes, status codes and operation codes of the block pool allocator.
package gbpa_pkg;

   // Pool and handle space
   localparam int unsigned MAX_POOLS          = 8;
   localparam int unsigned MAX_ITEMS_PER_POOL = 64;
   localparam int unsigned HANDLE_SPACE       = MAX_POOLS * MAX_ITEMS_PER_POOL;

   localparam int unsigned POOL_W   = $clog2(MAX_POOLS);
   localparam int unsigned SLOT_W   = $clog2(MAX_ITEMS_PER_POOL);
   localparam int unsigned HANDLE_W = POOL_W + SLOT_W;
   localparam int unsigned PC_W     = $clog2(MAX_POOLS + 1);
   localparam int unsigned CNT_W    = $clog2(HANDLE_SPACE + 1);

   // Field widths
   localparam int unsigned FUNC_W   = 2;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned OFF_W    = 22;
   localparam int unsigned BYTES_W  = 16;
   localparam int unsigned NPOOL_W  = 4;
   localparam int unsigned PP_W     = 7;

   // Stream and register port widths
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 64;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   // Operation codes
   localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
   localparam logic [FUNC_W-1:0] FN_FREE  = 2'd1;
   localparam logic [FUNC_W-1:0] FN_CLEAN = 2'd2;
   localparam logic [FUNC_W-1:0] FN_INIT  = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] STS_OK            = 3'd0;
   localparam logic [STATUS_W-1:0] STS_EXHAUSTED     = 3'd1;
   localparam logic [STATUS_W-1:0] STS_GROW_FAILED   = 3'd2;
   localparam logic [STATUS_W-1:0] STS_NOT_IN_USE    = 3'd3;
   localparam logic [STATUS_W-1:0] STS_ALREADY_INIT  = 3'd4;
   localparam logic [STATUS_W-1:0] STS_BAD_CONFIG    = 3'd5;
   localparam logic [STATUS_W-1:0] STS_NOTHING_CLEAN = 3'd6;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ITEM_BYTES     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DYNAMIC_GROW   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_POOLS  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ITEMS_PER_POOL = 2'd3;

   // Register reset values
   localparam logic [BYTES_W-1:0] ITEM_BYTES_RST     = 16'd64;
   localparam logic [NPOOL_W-1:0] INITIAL_POOLS_RST  = 4'd1;
   localparam logic [PP_W-1:0]    ITEMS_PER_POOL_RST = 7'd64;

endpackage

FILE: rtl/growable_block_pool_allocator_top.sv
// Growable fixed-size block pool allocator: FIFO free list and used bits in block RAM.
// Sequence: alloc, free, cleanup and a non-growing init pass from idle through exec to done,
//   which registers the response beat; a new request is taken only back in idle, and done waits
//   while a pending beat is held by rsp_tready. Each pool added (by init or by an alloc on an
//   empty list) walks the pool's 64 slots through the free-list RAM in the grow state.
// Reset: synchronous; pointers, counts and latched settings clear, registers take defaults.
//   Free-list and used-bit RAMs are not cleared; used bits are qualified by the pool count.
module growable_block_pool_allocator_top (
   input  logic                               clock,
   input  logic                               reset,
   // request beat: tdata = free_handle[8:0]; tuser = func[1:0]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [gbpa_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [gbpa_pkg::FUNC_W-1:0]        req_tuser,
   // response beat: tdata = status[2:0], alloc_handle[11:3], pool_number[14:12],
   //   byte_offset[36:15], free_count[46:37], total_items[56:47]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [gbpa_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // register write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [gbpa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gbpa_pkg::CSR_DATA_W-1:0]    csr_data
);
   import gbpa_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_GROW = 3'd2;
   localparam logic [2:0] ST_WAIT = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   localparam int unsigned PAD_W = RSP_DATA_W - (2 * CNT_W + OFF_W + POOL_W + HANDLE_W
                                                 + STATUS_W);

   // configuration registers
   logic [BYTES_W-1:0]  item_bytes_ff;
   logic                dyn_grow_ff;
   logic [NPOOL_W-1:0]  init_pools_ff;
   logic [PP_W-1:0]     per_pool_ff;

   // latched settings
   logic [BYTES_W-1:0]  lat_bytes_ff, lat_bytes_in;
   logic [PP_W-1:0]     lat_per_pool_ff, lat_per_pool_in;
   logic                lat_grow_ff, lat_grow_in;

   // control state
   logic [2:0]          state_ff, state_in;
   logic [HANDLE_W-1:0] head_ff, head_in;
   logic [HANDLE_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [PC_W-1:0]     pool_count_ff, pool_count_in;
   logic [CNT_W-1:0]    slot_total_ff, slot_total_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [NPOOL_W-1:0]  pools_left_ff, pools_left_in;
   logic                grow_init_ff, grow_init_in;
   logic                grown_ff, grown_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [FUNC_W-1:0]     func_ff, func_in;
   logic [HANDLE_W-1:0]   fh_ff, fh_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [HANDLE_W-1:0]   res_handle_ff, res_handle_in;
   logic [OFF_W-1:0]      res_offset_ff, res_offset_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // memories
   logic [HANDLE_W-1:0] fifo_mem [HANDLE_SPACE];
   logic                used_mem [HANDLE_SPACE];
   logic [HANDLE_W-1:0] fifo_rd_ff;
   logic                used_rd_ff;

   logic                fifo_we;
   logic [HANDLE_W-1:0] fifo_wdata;
   logic                used_we;
   logic [HANDLE_W-1:0] used_waddr;
   logic                used_wdata;

   logic                req_accept;
   logic [HANDLE_W-1:0] grow_handle;
   logic                slot_last;
   logic                push_slot;
   logic                bad_config;
   logic                fh_pool_live;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign grow_handle  = {pool_count_ff[POOL_W-1:0], slot_ff};
   assign slot_last    = (slot_ff == SLOT_W'(MAX_ITEMS_PER_POOL - 1));
   assign push_slot    = (PP_W'(slot_ff) < lat_per_pool_ff);
   assign fh_pool_live = (PC_W'(fh_ff[HANDLE_W-1:SLOT_W]) < pool_count_ff);
   assign bad_config   = (item_bytes_ff == '0) || (init_pools_ff == '0) ||
                         (per_pool_ff == '0) || (per_pool_ff > PP_W'(MAX_ITEMS_PER_POOL));

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         item_bytes_ff <= ITEM_BYTES_RST;
         dyn_grow_ff   <= 1'b1;
         init_pools_ff <= INITIAL_POOLS_RST;
         per_pool_ff   <= ITEMS_PER_POOL_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ITEM_BYTES:     item_bytes_ff <= csr_data[BYTES_W-1:0];
            CSR_DYNAMIC_GROW:   dyn_grow_ff   <= csr_data[0];
            CSR_INITIAL_POOLS:  init_pools_ff <= csr_data[NPOOL_W-1:0];
            CSR_ITEMS_PER_POOL: per_pool_ff   <= csr_data[PP_W-1:0];
         endcase
      end
   end

   // sequencer: read, decide, write back
   always_comb begin
      state_in        = state_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      count_in        = count_ff;
      pool_count_in   = pool_count_ff;
      slot_total_in   = slot_total_ff;
      slot_in         = slot_ff;
      pools_left_in   = pools_left_ff;
      grow_init_in    = grow_init_ff;
      grown_in        = grown_ff;
      lat_bytes_in    = lat_bytes_ff;
      lat_per_pool_in = lat_per_pool_ff;
      lat_grow_in     = lat_grow_ff;
      func_in         = func_ff;
      fh_in           = fh_ff;
      res_status_in   = res_status_ff;
      res_handle_in   = res_handle_ff;
      res_offset_in   = res_offset_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      fifo_we         = 1'b0;
      fifo_wdata      = grow_handle;
      used_we         = 1'b0;
      used_waddr      = grow_handle;
      used_wdata      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               func_in  = req_tuser;
               fh_in    = req_tdata[HANDLE_W-1:0];
               grown_in = 1'b0;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            res_status_in = STS_OK;
            res_handle_in = '0;
            res_offset_in = '0;
            state_in      = ST_DONE;
            unique case (func_ff)
               FN_ALLOC: begin
                  if (count_ff == '0) begin
                     if (grown_ff || !lat_grow_ff) begin
                        res_status_in = STS_EXHAUSTED;
                     end else if (pool_count_ff >= PC_W'(MAX_POOLS)) begin
                        res_status_in = STS_GROW_FAILED;
                     end else begin
                        slot_in       = '0;
                        pools_left_in = NPOOL_W'(1);
                        grow_init_in  = 1'b0;
                        state_in      = ST_GROW;
                     end
                  end else begin
                     // pop the front handle and mark it used
                     used_we       = 1'b1;
                     used_waddr    = fifo_rd_ff;
                     used_wdata    = 1'b1;
                     head_in       = head_ff + 1'b1;
                     count_in      = count_ff - 1'b1;
                     res_handle_in = fifo_rd_ff;
                     res_offset_in = OFF_W'(fifo_rd_ff[SLOT_W-1:0]) * OFF_W'(lat_bytes_ff);
                  end
               end

               FN_FREE: begin
                  if (!fh_pool_live || !used_rd_ff) begin
                     res_status_in = STS_NOT_IN_USE;
                  end else begin
                     used_we    = 1'b1;
                     used_waddr = fh_ff;
                     used_wdata = 1'b0;
                     fifo_we    = 1'b1;
                     fifo_wdata = fh_ff;
                     tail_in    = tail_ff + 1'b1;
                     count_in   = count_ff + 1'b1;
                  end
               end

               FN_CLEAN: begin
                  if (pool_count_ff == '0) begin
                     res_status_in = STS_NOTHING_CLEAN;
                  end else begin
                     head_in       = '0;
                     tail_in       = '0;
                     count_in      = '0;
                     pool_count_in = '0;
                     slot_total_in = '0;
                  end
               end

               FN_INIT: begin
                  if (pool_count_ff != '0) begin
                     res_status_in = STS_ALREADY_INIT;
                  end else if (bad_config) begin
                     res_status_in = STS_BAD_CONFIG;
                  end else begin
                     lat_bytes_in    = item_bytes_ff;
                     lat_per_pool_in = per_pool_ff;
                     lat_grow_in     = 1'b1;
                     // asking for more pools than exist fails with no pool added, though the settings are latched
                     if (init_pools_ff > NPOOL_W'(MAX_POOLS)) begin
                        res_status_in = STS_GROW_FAILED;
                     end else begin
                        slot_in       = '0;
                        pools_left_in = init_pools_ff;
                        grow_init_in  = 1'b1;
                        state_in      = ST_GROW;
                     end
                  end
               end
            endcase
         end

         ST_GROW: begin
            // one slot per cycle: clear its used bit, push it if inside the pool size
            used_we = 1'b1;
            if (push_slot) begin
               fifo_we  = 1'b1;
               tail_in  = tail_ff + 1'b1;
               count_in = count_ff + 1'b1;
            end
            slot_in = slot_ff + 1'b1;
            if (slot_last) begin
               pool_count_in = pool_count_ff + 1'b1;
               slot_total_in = slot_total_ff + CNT_W'(lat_per_pool_ff);
               pools_left_in = pools_left_ff - 1'b1;
               if (pools_left_ff == NPOOL_W'(1)) begin
                  if (grow_init_ff) begin
                     lat_grow_in = dyn_grow_ff;
                     state_in    = ST_DONE;
                  end else begin
                     grown_in = 1'b1;
                     state_in = ST_WAIT;
                  end
               end
            end
         end

         // let the free-list read see the last pushed entry
         ST_WAIT: state_in = ST_EXEC;

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {PAD_W'(0), slot_total_ff, count_ff, res_offset_ff,
                               res_handle_ff[HANDLE_W-1:SLOT_W], res_handle_ff,
                               res_status_ff};
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         head_ff         <= '0;
         tail_ff         <= '0;
         count_ff        <= '0;
         pool_count_ff   <= '0;
         slot_total_ff   <= '0;
         slot_ff         <= '0;
         pools_left_ff   <= '0;
         grow_init_ff    <= 1'b0;
         grown_ff        <= 1'b0;
         lat_bytes_ff    <= '0;
         lat_per_pool_ff <= '0;
         lat_grow_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         head_ff         <= head_in;
         tail_ff         <= tail_in;
         count_ff        <= count_in;
         pool_count_ff   <= pool_count_in;
         slot_total_ff   <= slot_total_in;
         slot_ff         <= slot_in;
         pools_left_ff   <= pools_left_in;
         grow_init_ff    <= grow_init_in;
         grown_ff        <= grown_in;
         lat_bytes_ff    <= lat_bytes_in;
         lat_per_pool_ff <= lat_per_pool_in;
         lat_grow_ff     <= lat_grow_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      fh_ff         <= fh_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      res_offset_ff <= res_offset_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // free-list RAM: write at tail, registered read at head
   always_ff @(posedge clock) begin
      if (fifo_we) begin
         fifo_mem[tail_ff] <= fifo_wdata;
      end
      fifo_rd_ff <= fifo_mem[head_ff];
   end

   // used-bit RAM: registered read of the request's handle
   always_ff @(posedge clock) begin
      if (used_we) begin
         used_mem[used_waddr] <= used_wdata;
      end
      if (req_accept) begin
         used_rd_ff <= used_mem[req_tdata[HANDLE_W-1:0]];
      end
   end

   // free handles never outnumber the slots of live pools (the total lags during a walk)
   a_count_le_total: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_GROW |-> count_ff <= slot_total_ff)
      else $error("free count above total slots");

   // ring pointers agree with the fill count
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      HANDLE_W'(tail_ff - head_ff) == count_ff[HANDLE_W-1:0])
      else $error("free-list pointers disagree with count");

   // slot total tracks pools times latched pool size
   a_slot_total: assert property (@(posedge clock) disable iff (reset)
      slot_total_ff == CNT_W'(pool_count_ff) * CNT_W'(lat_per_pool_ff))
      else $error("slot total out of step with pool count");

   // a pool walk only runs with a room for the pool and a nonzero size
   a_grow_legal: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_GROW |-> (lat_per_pool_ff != '0) &&
                              (pool_count_ff < PC_W'(MAX_POOLS)))
      else $error("pool walk without room");

   // a response beat appears only out of the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("response raised outside done state");

endmodule
